// ===== hw/rtl/tpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcc_pkg
// Shared types and constants of the trie prefix conflict checker.
// ----------------------------------------------------------------------------
package tpcc_pkg;

    localparam int NODES    = 1024;
    localparam int ALPHABET = 16;
    localparam int SYM_W    = 4;
    localparam int NODE_W   = $clog2(NODES);
    localparam int ALPHA_W  = $clog2(ALPHABET);
    localparam int SLOT_W   = NODE_W + ALPHA_W;
    localparam int FREE_W   = NODE_W + 1;
    localparam int SLOTS    = NODES * ALPHABET;

    typedef struct packed {
        logic             opcode;
        logic [SYM_W-1:0] symbol;
        logic             last_symbol;
    } in_item_t;

    typedef struct packed {
        logic prefix_free;
        logic word_complete;
        logic table_full;
    } out_item_t;

    localparam logic OP_SYMBOL  = 1'b0;
    localparam logic OP_NEW_SET = 1'b1;

    typedef struct packed {
        logic [SLOT_W-1:0] parent;
        logic              word_end;
    } node_info_t;

    typedef struct packed {
        logic capture;
        logic rd_info;
        logic check;
        logic mark;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic direct;
        logic alloc;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/trie_prefix_conflict_check_core.sv =====
// ----------------------------------------------------------------------------
// trie_prefix_conflict_check_core
// Builds a trie of words one symbol per transaction and reports whether the
// set stays prefix-free, whether the word ended, and whether the store ran out.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data  (opcode, symbol, last_symbol)
// out      output     out_valid / out_ready out_data (prefix_free, word_complete,
//                                                     table_full)
//
// A new-set or skipped symbol goes from capture to the result step; a symbol on
// an existing edge adds the node lookup and check, and one that allocates a node
// also the parent mark write, as the child pointer store and then the node record
// are read in turn. A new set needs no clearing pass: the allocation counter
// retires all old entries at once. Reset is asynchronous and active low. A
// result waiting in the output register does not block the next transaction,
// which stalls only when its own result is ready and the register is still full.
// ----------------------------------------------------------------------------
module trie_prefix_conflict_check_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpcc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tpcc_pkg::out_item_t out_data
);
    import tpcc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tpcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tpcc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/tpcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpcc_ctrl
// Sequencer for one item: capture, node lookup, check, parent mark (on allocation only), result.
// ----------------------------------------------------------------------------
module tpcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpcc_pkg::dp_status_t status,
    output tpcc_pkg::ctrl_cmd_t  cmd
);
    import tpcc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_CHECK = 5'b00100,
        S_MARK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.direct ? S_DONE : S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.rd_info = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.alloc ? S_MARK : S_DONE;
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tpcc_datapath.sv =====
// ----------------------------------------------------------------------------
// tpcc_datapath
// Child pointer store, node records, walk state, sticky flags and result
// register. A node record counts only below the allocation counter, and a
// child pointer only if the record of its node names that same slot.
// ----------------------------------------------------------------------------
module tpcc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpcc_pkg::in_item_t   in_data,
    input  tpcc_pkg::ctrl_cmd_t  cmd,
    output tpcc_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tpcc_pkg::out_item_t  out_data
);
    import tpcc_pkg::*;

    logic [NODE_W-1:0] child_mem [SLOTS];
    node_info_t        info_mem  [NODES];
    logic              hc_mem    [NODES];

    logic [NODE_W-1:0] cur_reg;
    logic [FREE_W-1:0] free_reg;
    logic              conflict_reg;
    logic              full_reg;
    logic              skip_reg;
    logic              complete_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic              last_reg;
    logic [NODE_W-1:0] child_q;
    node_info_t        info_q;
    logic              hc_q;

    logic              take_hit;
    logic              take_alloc;
    logic              take_full;
    logic [NODE_W-1:0] new_node;
    logic [NODE_W-1:0] info_addr;
    logic [SLOT_W-1:0] rd_slot;

    assign new_node  = free_reg[NODE_W-1:0];
    assign info_addr = take_hit ? child_q : new_node;
    assign rd_slot   = {cur_reg, in_data.symbol[ALPHA_W-1:0]};

    always_comb
    begin
        take_hit   = 1'b0;
        take_alloc = 1'b0;
        take_full  = 1'b0;
        if ((child_q != '0) && (FREE_W'(child_q) < free_reg) && (info_q.parent == slot_reg))
        begin
            take_hit = 1'b1;
        end
        else if (free_reg < FREE_W'(NODES))
        begin
            take_alloc = 1'b1;
        end
        else
        begin
            take_full = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            child_q <= child_mem[rd_slot];
        end
        if (cmd.check && take_alloc)
        begin
            child_mem[slot_reg] <= new_node;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_info)
        begin
            info_q <= info_mem[child_q];
        end
        if (cmd.check && (take_alloc || (take_hit && last_reg)))
        begin
            info_mem[info_addr] <= '{parent: slot_reg, word_end: last_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_info)
        begin
            hc_q <= hc_mem[child_q];
        end
        if (cmd.check && take_alloc)
        begin
            hc_mem[new_node] <= 1'b0;
        end
        else if (cmd.mark)
        begin
            hc_mem[slot_reg[SLOT_W-1 -: NODE_W]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg <= rd_slot;
            last_reg <= in_data.last_symbol;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= '{prefix_free:   !conflict_reg,
                              word_complete: complete_reg,
                              table_full:    full_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            free_reg      <= FREE_W'(1);
            conflict_reg  <= 1'b0;
            full_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            complete_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                if (in_data.opcode == OP_NEW_SET)
                begin
                    cur_reg      <= '0;
                    free_reg     <= FREE_W'(1);
                    conflict_reg <= 1'b0;
                    full_reg     <= 1'b0;
                    skip_reg     <= 1'b0;
                    complete_reg <= 1'b0;
                end
                else if (skip_reg)
                begin
                    complete_reg <= in_data.last_symbol;
                    if (in_data.last_symbol)
                    begin
                        skip_reg <= 1'b0;
                        cur_reg  <= '0;
                    end
                end
            end
            if (cmd.check)
            begin
                complete_reg <= last_reg;
                if (take_hit)
                begin
                    conflict_reg <= conflict_reg | info_q.word_end | (last_reg & hc_q);
                    cur_reg      <= last_reg ? '0 : child_q;
                end
                else if (take_alloc)
                begin
                    free_reg <= free_reg + FREE_W'(1);
                    cur_reg  <= last_reg ? '0 : new_node;
                end
                else if (take_full)
                begin
                    full_reg <= 1'b1;
                    skip_reg <= !last_reg;
                    if (last_reg)
                    begin
                        cur_reg <= '0;
                    end
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.direct   = (in_data.opcode == OP_NEW_SET) | skip_reg;
    assign status.alloc    = take_alloc;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule
